// ===== src/fdrd_pkg.sv =====
// Shared types, constants and helpers of the frame dirty-rectangle detector.
// Used by every module of the block but fdrd_ram; depends on nothing else.
`default_nettype none

package fdrd_pkg;

  // Frame store geometry
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int DIMW_W      = $clog2(MAX_WIDTH + 1);
  localparam int DIMH_W      = $clog2(MAX_HEIGHT + 1);
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  // Field widths of the stream and register interfaces
  localparam int IN_DIM_W    = 11;
  localparam int COLOR_W     = 8;
  localparam int PIX_W       = 3 * COLOR_W;
  localparam int SCR_W       = 11;
  localparam int RECT_LO_W   = 10;
  localparam int RECT_HI_W   = 11;
  localparam int IN_FIELDS_W = 2 * IN_DIM_W + PIX_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * RECT_LO_W + 2 * RECT_HI_W;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELDS_W;

  // Configuration port
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = SCR_W;
  localparam logic [SCR_W-1:0] SCREEN_RESET = SCR_W'(1024);

  // Result queue
  localparam int RES_DEPTH   = 4;
  localparam int RES_PTR_W   = $clog2(RES_DEPTH);
  localparam int RES_CNT_W   = $clog2(RES_DEPTH + 1);

  // Width for comparing box edges against the screen size
  localparam int CMPX_W = (DIMW_W > SCR_W) ? DIMW_W : SCR_W;
  localparam int CMPY_W = (DIMH_W > SCR_W) ? DIMH_W : SCR_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIFF_DISABLE  = 2'd0,
    REG_SCREEN_WIDTH  = 2'd1,
    REG_SCREEN_HEIGHT = 2'd2
  } cfg_reg_e;

  // One classified pixel on its way from the front to the compare stage
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] x;
    logic [ROW_W-1:0] y;
    logic             start;
    logic             last;
    logic             full;
  } fdrd_item_t;

  // One dirty rectangle result
  typedef struct packed {
    logic [RECT_LO_W-1:0] left;
    logic [RECT_LO_W-1:0] top;
    logic [RECT_HI_W-1:0] right;
    logic [RECT_HI_W-1:0] bottom;
    logic                 full;
  } fdrd_rect_t;

  // Clamp an incoming width to 1..MAX_WIDTH
  function automatic logic [DIMW_W-1:0] limit_w(input logic [IN_DIM_W-1:0] v);
    if (v == '0) return DIMW_W'(1);
    if (32'(v) > 32'(MAX_WIDTH)) return DIMW_W'(MAX_WIDTH);
    return DIMW_W'(v);
  endfunction

  // Clamp an incoming height to 1..MAX_HEIGHT
  function automatic logic [DIMH_W-1:0] limit_h(input logic [IN_DIM_W-1:0] v);
    if (v == '0) return DIMH_W'(1);
    if (32'(v) > 32'(MAX_HEIGHT)) return DIMH_W'(MAX_HEIGHT);
    return DIMH_W'(v);
  endfunction

endpackage

`default_nettype wire

// ===== src/fdrd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read-first: a read and write of the same address returns the old word.
`default_nettype none

module fdrd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read old contents, then write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/fdrd_front.sv =====
// Front end: raster counters, frame-start classification and frame store access.
// Depends on fdrd_pkg; drives the frame store RAM and the compare stage register.
`default_nettype none

module fdrd_front import fdrd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                take_i,
  input  wire logic [IN_DIM_W-1:0] width_i,
  input  wire logic [IN_DIM_W-1:0] height_i,
  input  wire logic [PIX_W-1:0]    pixel_i,
  input  wire logic                diff_disable_i,
  output      logic                ram_we_o,
  output      logic [STORE_AW-1:0] ram_addr_o,
  output      logic [PIX_W-1:0]    ram_wdata_o,
  output      logic                s1_valid_o,
  output      fdrd_item_t          s1_item_o
);

  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [DIMW_W-1:0] stored_w_q, stored_w_d;
  logic [DIMH_W-1:0] stored_h_q, stored_h_d;
  logic              store_valid_q;
  logic              full_q, full_d;
  logic              s1_valid_q;
  fdrd_item_t        s1_item_q, s1_item_d;

  logic              start;
  logic [DIMW_W-1:0] lim_w;
  logic [DIMH_W-1:0] lim_h;
  logic [DIMW_W-1:0] col_inc;
  logic [DIMH_W-1:0] row_inc;
  logic              wrap_col;
  logic              last;

  // Classify the pixel and advance the raster position
  always_comb begin
    start      = (col_q == '0) && (row_q == '0);
    lim_w      = limit_w(width_i);
    lim_h      = limit_h(height_i);
    stored_w_d = start ? lim_w : stored_w_q;
    stored_h_d = start ? lim_h : stored_h_q;
    full_d     = start ? (diff_disable_i || !store_valid_q ||
                          (lim_w != stored_w_q) || (lim_h != stored_h_q))
                       : full_q;
    col_inc    = DIMW_W'(col_q) + DIMW_W'(1);
    row_inc    = DIMH_W'(row_q) + DIMH_W'(1);
    wrap_col   = col_inc >= stored_w_d;
    last       = wrap_col && (row_inc >= stored_h_d);
    col_d      = wrap_col ? '0 : col_inc[COL_W-1:0];
    row_d      = row_q;
    if (wrap_col) begin
      row_d = last ? '0 : row_inc[ROW_W-1:0];
    end
    s1_item_d.pixel = pixel_i;
    s1_item_d.x     = col_q;
    s1_item_d.y     = row_q;
    s1_item_d.start = start;
    s1_item_d.last  = last;
    s1_item_d.full  = full_d;
  end

  // Read the old pixel and write the new one at the same entry
  assign ram_we_o    = take_i;
  assign ram_addr_o  = STORE_AW'(row_q) * STORE_AW'(MAX_WIDTH) + STORE_AW'(col_q);
  assign ram_wdata_o = pixel_i;

  // Hold raster and frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q         <= '0;
      row_q         <= '0;
      stored_w_q    <= '0;
      stored_h_q    <= '0;
      store_valid_q <= 1'b0;
      full_q        <= 1'b0;
      s1_valid_q    <= 1'b0;
    end else begin
      s1_valid_q <= take_i;
      if (take_i) begin
        col_q         <= col_d;
        row_q         <= row_d;
        stored_w_q    <= stored_w_d;
        stored_h_q    <= stored_h_d;
        store_valid_q <= 1'b1;
        full_q        <= full_d;
      end
    end
  end

  // Carry the item alongside the registered store read
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      s1_item_q <= s1_item_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_item_o  = s1_item_q;

endmodule

`default_nettype wire

// ===== src/fdrd_diff.sv =====
// Compare stage: checks each pixel against the stored one, tracks the bounding
// box and forms the rectangle at the last pixel. Depends on fdrd_pkg.
`default_nettype none

module fdrd_diff import fdrd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire fdrd_item_t       item_i,
  input  wire logic [PIX_W-1:0] old_pixel_i,
  input  wire logic [SCR_W-1:0] screen_w_i,
  input  wire logic [SCR_W-1:0] screen_h_i,
  output      logic             push_o,
  output      fdrd_rect_t       rect_o
);

  logic             any_q, any_d;
  logic [COL_W-1:0] min_x_q, min_x_d, max_x_q, max_x_d;
  logic [ROW_W-1:0] min_y_q, min_y_d, max_y_q, max_y_d;

  logic             base_any;
  logic             changed;
  logic [SCR_W-1:0] sw, sh;
  logic [CMPX_W-1:0] right_raw;
  logic [CMPY_W-1:0] bottom_raw;

  // Grow the box with a changed pixel; a frame start empties it
  always_comb begin
    base_any = item_i.start ? 1'b0 : any_q;
    changed  = !item_i.full && (old_pixel_i != item_i.pixel);
    any_d    = base_any || changed;
    min_x_d  = min_x_q;
    max_x_d  = max_x_q;
    min_y_d  = min_y_q;
    max_y_d  = max_y_q;
    if (changed) begin
      if (!base_any) begin
        min_x_d = item_i.x;
        max_x_d = item_i.x;
        min_y_d = item_i.y;
        max_y_d = item_i.y;
      end else begin
        if (item_i.x < min_x_q) min_x_d = item_i.x;
        if (item_i.x > max_x_q) max_x_d = item_i.x;
        if (item_i.y < min_y_q) min_y_d = item_i.y;
        if (item_i.y > max_y_q) max_y_d = item_i.y;
      end
    end
  end

  // Form the rectangle, exclusive edges clipped to the screen
  always_comb begin
    sw         = (screen_w_i == '0) ? SCR_W'(1) : screen_w_i;
    sh         = (screen_h_i == '0) ? SCR_W'(1) : screen_h_i;
    right_raw  = CMPX_W'(max_x_d) + CMPX_W'(1);
    bottom_raw = CMPY_W'(max_y_d) + CMPY_W'(1);
    if (right_raw > CMPX_W'(sw)) right_raw = CMPX_W'(sw);
    if (bottom_raw > CMPY_W'(sh)) bottom_raw = CMPY_W'(sh);
    if (item_i.full) begin
      rect_o.left   = '0;
      rect_o.top    = '0;
      rect_o.right  = RECT_HI_W'(sw);
      rect_o.bottom = RECT_HI_W'(sh);
      rect_o.full   = 1'b1;
    end else begin
      rect_o.left   = RECT_LO_W'(min_x_d);
      rect_o.top    = RECT_LO_W'(min_y_d);
      rect_o.right  = RECT_HI_W'(right_raw);
      rect_o.bottom = RECT_HI_W'(bottom_raw);
      rect_o.full   = 1'b0;
    end
    push_o = valid_i && item_i.last && (item_i.full || any_d);
  end

  // Hold the box between pixels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q <= 1'b0;
    end else if (valid_i) begin
      any_q <= any_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      min_x_q <= min_x_d;
      max_x_q <= max_x_d;
      min_y_q <= min_y_d;
      max_y_q <= max_y_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/fdrd_fifo.sv =====
// Result queue between the compare stage and the output stream.
// Depends on fdrd_pkg; the read-pointer entry drives the output.
`default_nettype none

module fdrd_fifo import fdrd_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire fdrd_rect_t           data_i,
  input  wire logic                 pop_i,
  output      logic                 valid_o,
  output      fdrd_rect_t           data_o,
  output      logic [RES_CNT_W-1:0] count_o
);

  fdrd_rect_t           mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [RES_CNT_W-1:0] count_q, count_d;
  logic                 do_pop;

  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (push_i && !do_pop) count_d = count_q + RES_CNT_W'(1);
    if (!push_i && do_pop) count_d = count_q - RES_CNT_W'(1);
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + RES_PTR_W'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
      count_q <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/frame_dirty_rectangle_detector.sv =====
// Frame dirty-rectangle detector, top level. Takes one pixel per clock
// while the result queue has room. Throughput: 1 pixel per cycle while
// the queue has room, set by one read and one write per cycle on the
// frame store RAM; results queue in a 4-entry buffer.
// Reset: counters, frame state and queue clear at once; the frame store is
// not cleared, and the first frame after reset is a full-screen update.
`default_nettype none

module frame_dirty_rectangle_detector import fdrd_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // tdata: image_width[10:0], image_height[21:11], red[29:22],
  // green[37:30], blue[45:38], zero padding
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tdata: rect_left[9:0], rect_top[19:10], rect_right[30:20],
  // rect_bottom[41:31], zero padding
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: full_update[0]
  output      logic                   m_axis_tuser,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  logic             diff_disable_q;
  logic [SCR_W-1:0] screen_w_q, screen_h_q;

  logic                take;
  logic [IN_DIM_W-1:0] in_width, in_height;
  logic [PIX_W-1:0]    in_pixel;
  logic                ram_we;
  logic [STORE_AW-1:0] ram_addr;
  logic [PIX_W-1:0]    ram_wdata;
  logic [PIX_W-1:0]    ram_rdata;
  logic                s1_valid;
  fdrd_item_t          s1_item;
  logic                push;
  fdrd_rect_t          push_rect;
  fdrd_rect_t          head_rect;
  logic [RES_CNT_W-1:0] res_count;
  logic [RES_CNT_W:0]  res_reserved;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_disable_q <= 1'b0;
      screen_w_q     <= SCREEN_RESET;
      screen_h_q     <= SCREEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_DIFF_DISABLE:  diff_disable_q <= cfg_wdata_i[0];
        REG_SCREEN_WIDTH:  screen_w_q     <= cfg_wdata_i[SCR_W-1:0];
        REG_SCREEN_HEIGHT: screen_h_q     <= cfg_wdata_i[SCR_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the pixel request
  assign in_width  = s_axis_tdata[IN_DIM_W-1:0];
  assign in_height = s_axis_tdata[2*IN_DIM_W-1:IN_DIM_W];
  assign in_pixel  = {s_axis_tdata[2*IN_DIM_W+COLOR_W-1:2*IN_DIM_W],
                      s_axis_tdata[2*IN_DIM_W+2*COLOR_W-1:2*IN_DIM_W+COLOR_W],
                      s_axis_tdata[2*IN_DIM_W+3*COLOR_W-1:2*IN_DIM_W+2*COLOR_W]};

  // Accept while the queue has room for every result still in flight
  assign res_reserved  = (RES_CNT_W+1)'(res_count) +
                         (RES_CNT_W+1)'(s1_valid && s1_item.last);
  assign s_axis_tready = res_reserved < (RES_CNT_W+1)'(RES_DEPTH);
  assign take          = s_axis_tvalid && s_axis_tready;

  fdrd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .width_i        (in_width),
    .height_i       (in_height),
    .pixel_i        (in_pixel),
    .diff_disable_i (diff_disable_q),
    .ram_we_o       (ram_we),
    .ram_addr_o     (ram_addr),
    .ram_wdata_o    (ram_wdata),
    .s1_valid_o     (s1_valid),
    .s1_item_o      (s1_item)
  );

  fdrd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .re_i    (take),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  fdrd_diff u_diff (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid),
    .item_i      (s1_item),
    .old_pixel_i (ram_rdata),
    .screen_w_i  (screen_w_q),
    .screen_h_i  (screen_h_q),
    .push_o      (push),
    .rect_o      (push_rect)
  );

  fdrd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_rect),
    .pop_i   (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .data_o  (head_rect),
    .count_o (res_count)
  );

  // Pack the result request
  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, head_rect.bottom, head_rect.right,
                         head_rect.top, head_rect.left};
  assign m_axis_tuser = head_rect.full;

endmodule

`default_nettype wire
